// ===== src/tntg_pkg.sv =====
// Shared types, hash and blend constants and the lerp function of the texel generator.
// Depends on nothing; every other file imports it.
package tntg_pkg;

    localparam int EDGE_LOG2 = 6;   // cube edge 64, power of two
    localparam int POS_W     = 6;
    localparam int CRD_W     = 10;  // lattice coordinate, period up to 6 << 7
    localparam int VAL_W     = 24;  // Q0.24 corner value and noise
    localparam int WGT_W     = 25;  // Q1.24 smoothstep weight
    localparam int P_W       = POS_W + CRD_W;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [CRD_W-1:0] crd_t;
    typedef logic [VAL_W-1:0] val_t;
    typedef logic [WGT_W-1:0] wgt_t;

    localparam logic [31:0] HASH_X = 32'd73856093;
    localparam logic [31:0] HASH_Y = 32'd19349663;
    localparam logic [31:0] HASH_Z = 32'd83492791;
    localparam logic [31:0] HASH_S = 32'd2654435761;
    localparam logic [31:0] MIX_A  = 32'h7feb352d;
    localparam logic [31:0] MIX_B  = 32'h846ca68b;

    localparam int K_062 = 10401874;
    localparam int K_028 = 4697620;
    localparam int K_010 = 1677722;
    localparam int K_042 = 7046431;
    localparam int K_016 = 2684355;

    localparam int GRAIN_SEED_MUL = 131;
    localparam int VEIN_SEED_ADD  = 900;
    localparam int OCT_SEED_STEP  = 17;

    typedef enum logic [2:0] {
        REG_CHANNEL = 3'd0,
        REG_ALB_R   = 3'd1,
        REG_ALB_G   = 3'd2,
        REG_ALB_B   = 3'd3,
        REG_ROUGH   = 3'd4
    } reg_idx_t;

    // a + floor((b - a) * s / 2^24), equal to the two-product lerp
    function automatic val_t blend(input val_t a, input val_t b, input wgt_t s);
        logic signed [25:0] diff;
        logic signed [51:0] prod;
        logic signed [51:0] sum;
        diff = $signed({2'b0, b}) - $signed({2'b0, a});
        prod = 52'(diff) * 52'($signed({1'b0, s}));
        sum  = $signed({28'b0, a}) + (prod >>> 24);
        return sum[VAL_W-1:0];
    endfunction

endpackage

// ===== src/tntg_hash.sv =====
// Four-stage corner hash: coordinate mix, then two multiply-xorshift rounds.
// Depends on tntg_pkg.
module tntg_hash
    import tntg_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  crd_t        cx,
    input  crd_t        cy,
    input  crd_t        cz,
    input  logic [31:0] seed,
    output val_t        value
);

    logic [31:0] mx_reg, my_reg, mz_reg, ms_reg;
    logic [31:0] mx_next, my_next, mz_next, ms_next;
    logic [31:0] ra_reg, ra_next, rb_reg, rb_next;
    val_t        val_reg, val_next;
    logic [31:0] k, va, vb, vc;

    always_comb begin
        mx_next  = {22'b0, cx} * HASH_X;
        my_next  = {22'b0, cy} * HASH_Y;
        mz_next  = {22'b0, cz} * HASH_Z;
        ms_next  = seed * HASH_S;
        k        = mx_reg ^ my_reg ^ mz_reg ^ ms_reg;
        va       = k ^ (k >> 16);
        ra_next  = va * MIX_A;
        vb       = ra_reg ^ (ra_reg >> 15);
        rb_next  = vb * MIX_B;
        vc       = rb_reg ^ (rb_reg >> 16);
        val_next = vc[31:8];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            mz_reg  <= mz_next;
            ms_reg  <= ms_next;
            ra_reg  <= ra_next;
            rb_reg  <= rb_next;
            val_reg <= val_next;
        end
    end

    assign value = val_reg;

endmodule

// ===== src/tntg_octave.sv =====
// One octave of tileable value noise: cell split, smoothstep, eight corner hashes,
// trilinear blend. Eight register stages. Depends on tntg_pkg and tntg_hash.
module tntg_octave
    import tntg_pkg::*;
#(
    parameter int OCT = 0
) (
    input  logic            aclk,
    input  logic            en,
    input  pos_t [2:0]      pos,
    input  logic [2:0][2:0] base,
    input  logic [31:0]     seed,
    output val_t            noise
);

    crd_t [2:0] lo_reg, lo_next, hi_reg, hi_next;
    val_t [2:0] t_reg, t_next, td_reg, t2_reg, t2_next;
    wgt_t [2:0] s3_reg, s3_next, s4_reg, s5_reg;
    wgt_t       sy6_reg, sz6_reg, sz7_reg;
    val_t [7:0] cval;
    val_t [3:0] e_reg, e_next;
    val_t [1:0] f_reg, f_next;
    val_t       n_reg, n_next;

    always_comb begin
        crd_t             per;
        logic [P_W-1:0]   p;
        crd_t             cidx;
        crd_t             inc;
        logic [47:0]      tt;
        logic [25:0]      fw;
        logic [49:0]      sp;
        for (int a = 0; a < 3; a++) begin
            per        = crd_t'({7'b0, base[a]} << OCT);
            p          = {{CRD_W{1'b0}}, pos[a]} * {{POS_W{1'b0}}, per};
            cidx       = p[EDGE_LOG2 +: CRD_W];
            inc        = cidx + 10'd1;
            lo_next[a] = cidx;
            hi_next[a] = (inc == per) ? '0 : inc;
            t_next[a]  = val_t'(p[EDGE_LOG2-1:0]) << (VAL_W - EDGE_LOG2);
            tt         = {24'b0, t_reg[a]} * {24'b0, t_reg[a]};
            t2_next[a] = tt[47:24];
            fw         = 26'd50331648 - {1'b0, td_reg[a], 1'b0};
            sp         = {26'b0, t2_reg[a]} * {24'b0, fw};
            s3_next[a] = sp[48:24];
        end
        for (int j = 0; j < 4; j++) begin
            e_next[j] = blend(cval[2*j], cval[2*j+1], s5_reg[0]);
        end
        f_next[0] = blend(e_reg[0], e_reg[1], sy6_reg);
        f_next[1] = blend(e_reg[2], e_reg[3], sy6_reg);
        n_next    = blend(f_reg[0], f_reg[1], sz7_reg);
    end

    for (genvar c = 0; c < 8; c++) begin : g_corner
        tntg_hash u_hash (
            .aclk  (aclk),
            .en    (en),
            .cx    (c[0] ? hi_reg[0] : lo_reg[0]),
            .cy    (c[1] ? hi_reg[1] : lo_reg[1]),
            .cz    (c[2] ? hi_reg[2] : lo_reg[2]),
            .seed  (seed),
            .value (cval[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            t_reg   <= t_next;
            td_reg  <= t_reg;
            t2_reg  <= t2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s3_reg;
            s5_reg  <= s4_reg;
            sy6_reg <= s5_reg[1];
            sz6_reg <= s5_reg[2];
            sz7_reg <= sz6_reg;
            e_reg   <= e_next;
            f_reg   <= f_next;
            n_reg   <= n_next;
        end
    end

    assign noise = n_reg;

endmodule

// ===== src/tileable_noise_texel_generator_core.sv =====
// Top level of the tileable noise texel generator: config registers, octave banks,
// octave sums and the color/height output math. Depends on tntg_pkg and tntg_octave.
//
// One voxel coordinate in, one texel out, one item per clock unless m_tready stalls.
// From acceptance to m_tvalid an item passes eight stages in each octave (cell split,
// t*t, smoothstep, hash rounds, three lerp levels), then octave sum, grain and vein
// products, the vein roughness product, mix and height, albedo product and byte
// rounding. All octaves of both sums run side by side, so the pipeline length does
// not grow with OCTAVES. A stall on m_tready freezes every stage at once; s_tready
// is low only while a finished item waits in the output register and cannot move.
// Write config only while the pipeline is empty.
module tileable_noise_texel_generator_core
    import tntg_pkg::*;
#(
    parameter int OCTAVES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // voxel_x, voxel_y, voxel_z, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // red, green, blue, height
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int NSTG = 14;

    logic [3:0]      chan_reg;
    logic [16:0]     alb_r_reg, alb_g_reg, alb_b_reg, rough_reg;
    logic [NSTG-1:0] vld_reg;
    logic            en;

    pos_t [2:0]      pos;
    logic [2:0][2:0] gbase, vbase;
    logic [1:0]      vein_axis;
    val_t [OCTAVES-1:0] g_noise, v_noise;

    val_t              grain_reg, grain_next, vein_reg, vein_next;
    logic [23:0]       pg28_reg, pg28_next, pg28b_reg, pg50_reg, pg50_next, pg50b_reg;
    logic signed [43:0] dr_reg, dr_next;
    logic signed [25:0] hd_reg, hd_next, hdb_reg, mv_reg, mv_next;
    logic [24:0]       mix_reg, mix_next;
    logic signed [26:0] hgt_reg, hgt_next;
    logic [40:0]       cr_reg, cr_next, cg_reg, cg_next, cb_reg, cb_next;
    logic [24:0]       hc_reg, hc_next;
    logic [31:0]       out_reg, out_next;

    // advance the whole pipe unless the output item is stuck
    assign en       = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = out_reg;

    assign pos[0] = s_tdata[5:0];
    assign pos[1] = s_tdata[11:6];
    assign pos[2] = s_tdata[17:12];

    // vein period is 1 on axis channel mod 3, 2 elsewhere; grain 3 + channel mod 4
    always_comb begin
        case (chan_reg) inside
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: vein_axis = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       vein_axis = 2'd1;
            default:                              vein_axis = 2'd2;
        endcase
        for (int a = 0; a < 3; a++) begin
            gbase[a] = 3'd3 + {1'b0, chan_reg[1:0]};
            vbase[a] = (vein_axis == 2'(a)) ? 3'd1 : 3'd2;
        end
    end

    for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
        logic [31:0] gseed, vseed;
        assign gseed = {28'b0, chan_reg} * 32'(GRAIN_SEED_MUL) + 32'(o * OCT_SEED_STEP);
        assign vseed = 32'(VEIN_SEED_ADD) + {28'b0, chan_reg} + 32'(o * OCT_SEED_STEP);

        tntg_octave #(.OCT(o)) u_grain (
            .aclk  (aclk),
            .en    (en),
            .pos   (pos),
            .base  (gbase),
            .seed  (gseed),
            .noise (g_noise[o])
        );

        tntg_octave #(.OCT(o)) u_vein (
            .aclk  (aclk),
            .en    (en),
            .pos   (pos),
            .base  (vbase),
            .seed  (vseed),
            .noise (v_noise[o])
        );
    end

    always_comb begin
        logic [24:0]        gacc, vacc;
        logic signed [25:0] d;
        logic [47:0]        p28;
        logic signed [49:0] hp;
        logic signed [65:0] mp;
        logic signed [26:0] mixs;
        logic [41:0]        pr, pg, pb;
        logic [48:0]        qr, qg, qb;
        logic [32:0]        qh;

        // octave o contributes noise / 2^(o+1)
        gacc = '0;
        vacc = '0;
        for (int o = 0; o < OCTAVES; o++) begin
            gacc = gacc + 25'(g_noise[o] >> (o + 1));
            vacc = vacc + 25'(v_noise[o] >> (o + 1));
        end
        grain_next = gacc[VAL_W-1:0];
        vein_next  = vacc[VAL_W-1:0];

        // center vein on 0.5, form the products
        d         = $signed({2'b0, vein_reg}) - 26'sd8388608;
        p28       = 48'(K_028) * {24'b0, grain_reg};
        pg28_next = p28[47:24];
        pg50_next = {1'b0, grain_reg[23:1]};          // 0.50 * grain is a shift
        dr_next   = 44'(d) * 44'($signed({1'b0, rough_reg}));
        hp        = 50'(d) * 50'(K_016);
        hd_next   = 26'(hp >>> 24);

        mp      = 66'(dr_reg) * 66'(K_010);
        mv_next = 26'(mp >>> 40);

        // clamp mix at zero
        mixs     = 27'(K_062) + $signed({3'b0, pg28b_reg}) + 27'(mv_reg);
        mix_next = (mixs < 0) ? '0 : mixs[24:0];
        hgt_next = 27'(K_042) + $signed({3'b0, pg50b_reg}) + 27'(hdb_reg);

        // albedo * mix in Q40, clamp to 1.0; clamp height to 0..1.0
        pr      = 42'(alb_r_reg) * {17'b0, mix_reg};
        pg      = 42'(alb_g_reg) * {17'b0, mix_reg};
        pb      = 42'(alb_b_reg) * {17'b0, mix_reg};
        cr_next = (pr > (42'd1 << 40)) ? (41'd1 << 40) : pr[40:0];
        cg_next = (pg > (42'd1 << 40)) ? (41'd1 << 40) : pg[40:0];
        cb_next = (pb > (42'd1 << 40)) ? (41'd1 << 40) : pb[40:0];
        if (hgt_reg < 0) begin
            hc_next = '0;
        end else if (hgt_reg > 27'sd16777216) begin
            hc_next = 25'd16777216;
        end else begin
            hc_next = hgt_reg[24:0];
        end

        // times 255, round half up
        qr = {cr_reg, 8'b0} - 49'(cr_reg) + (49'd1 << 39);
        qg = {cg_reg, 8'b0} - 49'(cg_reg) + (49'd1 << 39);
        qb = {cb_reg, 8'b0} - 49'(cb_reg) + (49'd1 << 39);
        qh = {hc_reg, 8'b0} - 33'(hc_reg) + (33'd1 << 23);
        out_next = {qh[31:24], qb[47:40], qg[47:40], qr[47:40]};
    end

    // config registers; unknown index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg  <= '0;
            alb_r_reg <= 17'd65536;
            alb_g_reg <= 17'd65536;
            alb_b_reg <= 17'd65536;
            rough_reg <= 17'd32768;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CHANNEL: chan_reg  <= cfg_data[3:0];
                REG_ALB_R:   alb_r_reg <= cfg_data;
                REG_ALB_G:   alb_g_reg <= cfg_data;
                REG_ALB_B:   alb_b_reg <= cfg_data;
                REG_ROUGH:   rough_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            grain_reg <= grain_next;
            vein_reg  <= vein_next;
            pg28_reg  <= pg28_next;
            pg50_reg  <= pg50_next;
            dr_reg    <= dr_next;
            hd_reg    <= hd_next;
            mv_reg    <= mv_next;
            pg28b_reg <= pg28_reg;
            pg50b_reg <= pg50_reg;
            hdb_reg   <= hd_reg;
            mix_reg   <= mix_next;
            hgt_reg   <= hgt_next;
            cr_reg    <= cr_next;
            cg_reg    <= cg_next;
            cb_reg    <= cb_next;
            hc_reg    <= hc_next;
            out_reg   <= out_next;
        end
    end

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && en) |=> (vld_reg[0] == $past(s_tvalid && s_tready)))
        else $error("accepted item did not enter the pipe");

    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !en) |=> $stable(vld_reg))
        else $error("pipe moved during stall");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output stall");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule
